// ===== rtl/csp_pkg.sv =====
`default_nettype none

package csp_pkg;

  localparam logic [10:0] NODE_ID_RESET   = 11'd140;
  localparam logic [15:0] PERIOD_RESET    = 16'd20000;
  localparam logic [15:0] MIN_PULSE_RESET = 16'd500;
  localparam logic [15:0] MAX_PULSE_RESET = 16'd2500;
  localparam logic [15:0] WIDTH_RESET     = 16'd1500;

  // full-scale command byte, divisor of the width scaling
  localparam logic [23:0] CMD_FULL_SCALE  = 24'd255;

  typedef enum logic [1:0] {
    CFG_NODE_ID   = 2'd0,
    CFG_PERIOD    = 2'd1,
    CFG_MIN_PULSE = 2'd2,
    CFG_MAX_PULSE = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [10:0] node_id;
    logic [15:0] period_ticks;
    logic [15:0] min_pulse_us;
    logic [15:0] max_pulse_us;
  } cfg_t;

  typedef struct packed {
    logic is_frame;
    logic accepted;
  } item_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/csp_front.sv =====
`default_nettype none

module csp_front #(
  parameter int CHANNELS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic                        extended_format,
  input  wire logic [28:0]                 frame_id,
  input  wire logic [3:0]                  frame_len,
  input  wire logic [7:0][7:0]             data_bytes,
  input  wire csp_pkg::cfg_t               cfg,
  output logic                             push,
  output csp_pkg::item_ctrl_t              push_ctrl,
  output logic [CHANNELS-1:0][15:0]        push_widths,
  input  wire logic                        full
);

  logic [15:0] span;
  logic        hit;

  logic                          s1_valid;
  csp_pkg::item_ctrl_t           s1_ctrl;
  logic [CHANNELS-1:0][23:0]     s1_prod;

  logic                          s2_valid;
  csp_pkg::item_ctrl_t           s2_ctrl;
  logic [CHANNELS-1:0][23:0]     s2_prod;
  logic [CHANNELS-1:0][15:0]     s2_quot;

  logic                          s1_adv;
  logic                          s2_adv;
  logic [CHANNELS-1:0][15:0]     quot_next;

  assign span = (cfg.max_pulse_us >= cfg.min_pulse_us) ?
                (cfg.max_pulse_us - cfg.min_pulse_us) : 16'd0;

  assign hit = action && !extended_format &&
               (frame_id == {18'd0, cfg.node_id}) &&
               (frame_len == 4'(CHANNELS));

  assign s2_adv   = !s2_valid || !full;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_stall = !s1_adv;
  assign push     = s2_valid && !full;

  // x/255 estimate: x*(2^16+2^8+1) >> 24, low by at most one
  always_comb begin
    logic [40:0] acc;
    for (int i = 0; i < CHANNELS; i++) begin
      acc = {1'b0, s1_prod[i], 16'd0} + {9'd0, s1_prod[i], 8'd0} + {17'd0, s1_prod[i]};
      quot_next[i] = acc[39:24];
    end
  end

  // correct the estimate and add the minimum pulse
  always_comb begin
    logic [23:0] rem;
    logic [15:0] q;
    push_ctrl = s2_ctrl;
    for (int i = 0; i < CHANNELS; i++) begin
      rem = s2_prod[i] - ({s2_quot[i], 8'd0} - {8'd0, s2_quot[i]});
      q = (rem >= csp_pkg::CMD_FULL_SCALE) ? s2_quot[i] + 16'd1 : s2_quot[i];
      push_widths[i] = cfg.min_pulse_us + q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= in_valid;
      if (s2_adv) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_ctrl.is_frame <= action;
      s1_ctrl.accepted <= hit;
      for (int i = 0; i < CHANNELS; i++) begin
        s1_prod[i] <= {16'd0, data_bytes[i]} * {8'd0, span};
      end
    end
    if (s2_adv) begin
      s2_ctrl <= s1_ctrl;
      s2_prod <= s1_prod;
      s2_quot <= quot_next;
    end
  end

  a_hold_on_full: assert property (@(posedge clk) disable iff (rst)
    s2_valid && full |=> s2_valid)
    else $error("front stage dropped an item while the queue was full");

endmodule

`default_nettype wire

// ===== rtl/csp_fifo.sv =====
`default_nettype none

module csp_fifo #(
  parameter int CHANNELS = 8,
  parameter int DEPTH    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire csp_pkg::item_ctrl_t         push_ctrl,
  input  wire logic [CHANNELS-1:0][15:0]   push_widths,
  output logic                             full,
  output logic                             head_valid,
  output csp_pkg::item_ctrl_t              head_ctrl,
  output logic [CHANNELS-1:0][15:0]        head_widths,
  input  wire logic                        pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  csp_pkg::item_ctrl_t           ctrl_mem  [DEPTH];
  logic [CHANNELS-1:0][15:0]     width_mem [DEPTH];
  logic [PTR_W-1:0]              wr_ptr;
  logic [PTR_W-1:0]              rd_ptr;
  logic [CNT_W-1:0]              count;

  assign full        = (count == CNT_W'(DEPTH));
  assign head_valid  = (count != '0);
  assign head_ctrl   = ctrl_mem[rd_ptr];
  assign head_widths = width_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_mem[wr_ptr]  <= push_ctrl;
      width_mem[wr_ptr] <= push_widths;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

endmodule

`default_nettype wire

// ===== rtl/csp_back.sv =====
`default_nettype none

module csp_back #(
  parameter int CHANNELS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [15:0]                 period_ticks,
  input  wire logic                        head_valid,
  input  wire csp_pkg::item_ctrl_t         head_ctrl,
  input  wire logic [CHANNELS-1:0][15:0]   head_widths,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       pwm_levels,
  output logic                             frame_accepted
);

  logic [15:0]                   counter;
  logic [CHANNELS-1:0][15:0]     pending;
  logic [CHANNELS-1:0][15:0]     active;

  logic                          latch;
  logic [CHANNELS-1:0][15:0]     active_next;
  logic [7:0]                    levels_next;
  logic [16:0]                   counter_inc;
  logic [15:0]                   counter_next;

  assign pop = head_valid && (!out_valid || !out_stall);

  // a tick at period start promotes the pending widths first
  assign latch        = !head_ctrl.is_frame && (counter == 16'd0);
  assign counter_inc  = {1'b0, counter} + 17'd1;
  assign counter_next = (counter_inc >= {1'b0, period_ticks}) ? 16'd0 : counter_inc[15:0];

  always_comb begin
    levels_next = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      active_next[i] = latch ? pending[i] : active[i];
      levels_next[i] = (counter < active_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pending[i] <= csp_pkg::WIDTH_RESET;
        active[i]  <= csp_pkg::WIDTH_RESET;
      end
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (head_ctrl.is_frame) begin
          if (head_ctrl.accepted) pending <= head_widths;
        end else begin
          active  <= active_next;
          counter <= counter_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pwm_levels     <= levels_next;
      frame_accepted <= head_ctrl.is_frame && head_ctrl.accepted;
    end
  end

  a_frame_keeps_counter: assert property (@(posedge clk) disable iff (rst)
    pop && head_ctrl.is_frame |=> $stable(counter))
    else $error("frame moved the period counter");

  a_frame_keeps_active: assert property (@(posedge clk) disable iff (rst)
    pop && head_ctrl.is_frame |=> $stable(active))
    else $error("frame changed the active widths");

endmodule

`default_nettype wire

// ===== rtl/can_servo_pwm_controller.sv =====
// Path: an accepted input beat passes front stages s1 and s2, the queue, then the output registers.
// Throughput: one item per cycle while out_stall is low, ticks and frames alike; under out_stall
// the 4-entry queue takes the items first, and once it and the front stages are full, in_stall holds the input.
// Reset (rst, synchronous): registers go to node 140, period 20000, pulse 500..2500;
// all pending and active widths go to 1500, the period counter to zero, the queue to empty.
`default_nettype none

module can_servo_pwm_controller #(
  parameter int CHANNELS    = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic        extended_format,
  input  wire logic [28:0] frame_id,
  input  wire logic [3:0]  frame_len,
  input  wire logic [7:0]  data_byte_0,
  input  wire logic [7:0]  data_byte_1,
  input  wire logic [7:0]  data_byte_2,
  input  wire logic [7:0]  data_byte_3,
  input  wire logic [7:0]  data_byte_4,
  input  wire logic [7:0]  data_byte_5,
  input  wire logic [7:0]  data_byte_6,
  input  wire logic [7:0]  data_byte_7,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       pwm_levels,
  output logic             frame_accepted
);

  csp_pkg::cfg_t                 cfg;
  logic [7:0][7:0]               data_bytes;

  logic                          push;
  csp_pkg::item_ctrl_t           push_ctrl;
  logic [CHANNELS-1:0][15:0]     push_widths;
  logic                          full;
  logic                          head_valid;
  csp_pkg::item_ctrl_t           head_ctrl;
  logic [CHANNELS-1:0][15:0]     head_widths;
  logic                          pop;

  assign data_bytes = {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
                       data_byte_3, data_byte_2, data_byte_1, data_byte_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id      <= csp_pkg::NODE_ID_RESET;
      cfg.period_ticks <= csp_pkg::PERIOD_RESET;
      cfg.min_pulse_us <= csp_pkg::MIN_PULSE_RESET;
      cfg.max_pulse_us <= csp_pkg::MAX_PULSE_RESET;
    end else if (cfg_write) begin
      case (csp_pkg::cfg_index_t'(cfg_index))
        csp_pkg::CFG_NODE_ID:   cfg.node_id      <= cfg_data[10:0];
        csp_pkg::CFG_PERIOD:    cfg.period_ticks <= cfg_data;
        csp_pkg::CFG_MIN_PULSE: cfg.min_pulse_us <= cfg_data;
        csp_pkg::CFG_MAX_PULSE: cfg.max_pulse_us <= cfg_data;
        default: ;
      endcase
    end
  end

  csp_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .extended_format (extended_format),
    .frame_id        (frame_id),
    .frame_len       (frame_len),
    .data_bytes      (data_bytes),
    .cfg             (cfg),
    .push            (push),
    .push_ctrl       (push_ctrl),
    .push_widths     (push_widths),
    .full            (full)
  );

  csp_fifo #(
    .CHANNELS (CHANNELS),
    .DEPTH    (QUEUE_DEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_ctrl   (push_ctrl),
    .push_widths (push_widths),
    .full        (full),
    .head_valid  (head_valid),
    .head_ctrl   (head_ctrl),
    .head_widths (head_widths),
    .pop         (pop)
  );

  csp_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .period_ticks   (cfg.period_ticks),
    .head_valid     (head_valid),
    .head_ctrl      (head_ctrl),
    .head_widths    (head_widths),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pwm_levels     (pwm_levels),
    .frame_accepted (frame_accepted)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int NUM_CHANNELS = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic            is_frame;
    logic            ext;
    logic [28:0]     id;
    logic [3:0]      len;
    logic [7:0][7:0] data;
  } servo_item_t;

  typedef struct packed {
    logic [7:0] levels;
    logic       accepted;
  } servo_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  csp_pkg::cfg_index_t cfg_index = csp_pkg::CFG_NODE_ID;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic        extended_format = 1'b0;
  logic [28:0] frame_id = '0;
  logic [3:0]  frame_len = '0;
  logic [7:0]  data_byte_0 = '0;
  logic [7:0]  data_byte_1 = '0;
  logic [7:0]  data_byte_2 = '0;
  logic [7:0]  data_byte_3 = '0;
  logic [7:0]  data_byte_4 = '0;
  logic [7:0]  data_byte_5 = '0;
  logic [7:0]  data_byte_6 = '0;
  logic [7:0]  data_byte_7 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  pwm_levels;
  logic        frame_accepted;

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  // predictor state
  logic [10:0] node_reg;
  logic [15:0] period_reg;
  logic [15:0] min_reg;
  logic [15:0] max_reg;
  logic [15:0] period_cnt;
  logic [15:0] pending_w [NUM_CHANNELS];
  logic [15:0] active_w [NUM_CHANNELS];

  servo_result_t expected_levels_q [$];

  can_servo_pwm_controller DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .extended_format (extended_format),
    .frame_id        (frame_id),
    .frame_len       (frame_len),
    .data_byte_0     (data_byte_0),
    .data_byte_1     (data_byte_1),
    .data_byte_2     (data_byte_2),
    .data_byte_3     (data_byte_3),
    .data_byte_4     (data_byte_4),
    .data_byte_5     (data_byte_5),
    .data_byte_6     (data_byte_6),
    .data_byte_7     (data_byte_7),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pwm_levels      (pwm_levels),
    .frame_accepted  (frame_accepted)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic logic [15:0] cmd_to_width(input logic [7:0] b);
    logic [31:0] span;
    span = (max_reg >= min_reg) ? {16'd0, max_reg - min_reg} : 32'd0;
    return 16'({16'd0, min_reg} + ({24'd0, b} * span) / {8'd0, csp_pkg::CMD_FULL_SCALE});
  endfunction

  function automatic servo_result_t predict_servo(input servo_item_t it);
    servo_result_t r;
    logic [16:0] nxt;
    int i;
    r.accepted = 1'b0;
    if (!it.is_frame) begin
      // latch new widths at the period start
      if (period_cnt == 16'd0) begin
        for (i = 0; i < NUM_CHANNELS; i++) active_w[i] = pending_w[i];
      end
    end else if (!it.ext && it.id == {18'd0, node_reg} && it.len == 4'(NUM_CHANNELS)) begin
      r.accepted = 1'b1;
      for (i = 0; i < NUM_CHANNELS; i++) pending_w[i] = cmd_to_width(it.data[i]);
    end
    for (i = 0; i < NUM_CHANNELS; i++) r.levels[i] = (period_cnt < active_w[i]);
    if (!it.is_frame) begin
      nxt = {1'b0, period_cnt} + 17'd1;
      period_cnt = (nxt >= {1'b0, period_reg}) ? 16'd0 : nxt[15:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    servo_item_t seen;
    servo_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_levels_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", {24'd0, pwm_levels}, 0);
        end else begin
          want = expected_levels_q.pop_front();
          if (pwm_levels !== want.levels)
            report_mismatch("pwm_levels", {24'd0, pwm_levels}, {24'd0, want.levels});
          if (frame_accepted !== want.accepted)
            report_mismatch("frame_accepted", {31'd0, frame_accepted}, {31'd0, want.accepted});
        end
      end
      if (in_valid && !in_stall) begin
        seen.is_frame = action;
        seen.ext      = extended_format;
        seen.id       = frame_id;
        seen.len      = frame_len;
        seen.data     = {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
                         data_byte_3, data_byte_2, data_byte_1, data_byte_0};
        expected_levels_q.push_back(predict_servo(seen));
      end
    end
  end

  task automatic send_item(input servo_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= it.is_frame;
    extended_format <= it.ext;
    frame_id        <= it.id;
    frame_len       <= it.len;
    data_byte_0     <= it.data[0];
    data_byte_1     <= it.data[1];
    data_byte_2     <= it.data[2];
    data_byte_3     <= it.data[3];
    data_byte_4     <= it.data[4];
    data_byte_5     <= it.data[5];
    data_byte_6     <= it.data[6];
    data_byte_7     <= it.data[7];
    @(posedge clk);
    // hold the beat until it is taken
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_levels_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input csp_pkg::cfg_index_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      csp_pkg::CFG_NODE_ID:   node_reg = val[10:0];
      csp_pkg::CFG_PERIOD:    period_reg = val;
      csp_pkg::CFG_MIN_PULSE: min_reg = val;
      csp_pkg::CFG_MAX_PULSE: max_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [10:0] node, input logic [15:0] period,
                            input logic [15:0] min_w, input logic [15:0] max_w);
    write_reg(csp_pkg::CFG_NODE_ID, {5'd0, node});
    write_reg(csp_pkg::CFG_PERIOD, period);
    write_reg(csp_pkg::CFG_MIN_PULSE, min_w);
    write_reg(csp_pkg::CFG_MAX_PULSE, max_w);
    cfg_write <= 1'b0;
  endtask

  function automatic servo_item_t frame_item(input logic ext, input logic [28:0] id,
                                             input logic [3:0] len,
                                             input logic [7:0][7:0] data);
    servo_item_t it;
    it.is_frame = 1'b1;
    it.ext      = ext;
    it.id       = id;
    it.len      = len;
    it.data     = data;
    return it;
  endfunction

  function automatic servo_item_t rand_item(input logic [10:0] node);
    servo_item_t it;
    int pick;
    int i;
    it.is_frame = 1'b0;
    it.ext      = 1'($urandom_range(1));
    it.id       = 29'($urandom);
    it.len      = 4'($urandom);
    for (i = 0; i < NUM_CHANNELS; i++) begin
      it.data[i] = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                            : 8'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 88) return it;
    it.is_frame = 1'b1;
    if (pick < 95) begin
      it.ext = 1'b0;
      it.id  = {18'd0, node};
      it.len = 4'(NUM_CHANNELS);
    end else begin
      case ($urandom_range(3))
        0: begin
          it.ext = 1'b1;
          it.id  = {18'd0, node};
          it.len = 4'(NUM_CHANNELS);
        end
        1: begin
          it.ext = 1'b0;
          it.id  = {18'd0, node} ^ (29'd1 << $urandom_range(28));
          it.len = 4'(NUM_CHANNELS);
        end
        2: begin
          it.ext = 1'b0;
          it.id  = {18'd0, node};
          it.len = 4'($urandom_range(15));
          if (it.len == 4'(NUM_CHANNELS)) it.len = 4'(NUM_CHANNELS + 1);
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic test_defaults();
    servo_item_t tick_lo;
    servo_item_t tick_hi;
    logic [7:0][7:0] mixed;
    tick_lo = '0;
    tick_hi = '1;
    tick_hi.is_frame = 1'b0;
    mixed = {8'hAA, 8'h55, 8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'h00};
    idle_pct  = 0;
    stall_pct = 0;
    // commands land before the first tick, so they go live at once
    send_item(frame_item(1'b0, 29'd140, 4'd8, mixed));
    send_item(tick_lo);
    send_item(frame_item(1'b1, 29'd140, 4'd8, '0));
    send_item(frame_item(1'b0, 29'd140 | (29'd1 << 11), 4'd8, '1));
    send_item(frame_item(1'b0, 29'd140 | (29'd1 << 28), 4'd8, '1));
    send_item(frame_item(1'b0, 29'd139, 4'd8, '1));
    send_item(frame_item(1'b0, 29'd140, 4'd0, '1));
    send_item(frame_item(1'b0, 29'd140, 4'd7, '1));
    send_item(frame_item(1'b0, 29'd140, 4'd9, '1));
    send_item(frame_item(1'b0, 29'd140, 4'd15, '1));
    send_item(frame_item(1'b1, 29'h1FFFFFFF, 4'd15, '1));
    send_item(tick_hi);
    send_item(tick_lo);
    drain();
  endtask

  task automatic test_config_extremes();
    servo_item_t tick_lo;
    tick_lo = '0;
    // max below min: every byte maps to min
    set_config(11'd0, 16'd1000, 16'hFFFF, 16'd0);
    send_item(frame_item(1'b0, 29'd0, 4'd8, {8'hFF, 8'h00, 8'h80, 8'h01,
                                             8'hFE, 8'h7F, 8'hC3, 8'h3C}));
    send_item(tick_lo);
    drain();
    set_config(11'h7FF, 16'hFFFF, 16'd0, 16'hFFFF);
    send_item(frame_item(1'b0, 29'h7FF, 4'd8, {8'h00, 8'hFF, 8'h01, 8'hFE,
                                               8'h80, 8'h7F, 8'h00, 8'hFF}));
    send_item(frame_item(1'b0, 29'd0, 4'd8, '0));
    send_item(tick_lo);
    send_item(tick_lo);
    drain();
  endtask

  task automatic test_random_traffic(input int n, input int send_idle, input int recv_stall,
                                     input logic [10:0] node, input logic [15:0] period,
                                     input logic [15:0] min_w, input logic [15:0] max_w);
    set_config(node, period, min_w, max_w);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (n) send_item(rand_item(node));
    drain();
  endtask

  initial begin
    node_reg   = csp_pkg::NODE_ID_RESET;
    period_reg = csp_pkg::PERIOD_RESET;
    min_reg    = csp_pkg::MIN_PULSE_RESET;
    max_reg    = csp_pkg::MAX_PULSE_RESET;
    period_cnt = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pending_w[i] = csp_pkg::WIDTH_RESET;
      active_w[i]  = csp_pkg::WIDTH_RESET;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_config_extremes();
    // short periods in the first three runs so edges and the wrap show up
    test_random_traffic(450, 0, 0, 11'($urandom), 16'd1000, 16'd0, 16'd900);
    test_random_traffic(450, 86, 0, 11'($urandom), 16'd1000, 16'd300, 16'd100);
    test_random_traffic(450, 0, 86, 11'($urandom), 16'd1000,
                        16'($urandom_range(200)), 16'($urandom_range(1000, 600)));
    test_random_traffic(450, 25, 25, 11'h7FF, 16'hFFFF, 16'd0, 16'hFFFF);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/csp_pkg.sv
rtl/csp_front.sv
rtl/csp_fifo.sv
rtl/csp_back.sv
rtl/can_servo_pwm_controller.sv
tb/tb.sv
